/* hdl/esc_pkg.sv */
// esc_pkg: constants, calibration-register codes and wrapped-arithmetic helpers
// for the environmental sensor compensation pipeline.
// No dependencies; used by env_sensor_compensation.
package esc_pkg;

  // pipeline shape
  localparam int unsigned FRONT_STAGES = 15;  // up to and including divider setup
  localparam int unsigned DIV_STEPS    = 64;  // one quotient bit per stage
  localparam int unsigned BACK_STAGES  = 7;   // sign fix, pressure tail, output reg
  localparam int unsigned NUM_STAGES   = FRONT_STAGES + DIV_STEPS + BACK_STAGES;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEMP_CALIB    = 3'd0,
    REG_PRESS_CALIB_A = 3'd1,
    REG_PRESS_CALIB_B = 3'd2,
    REG_MIXED_CALIB   = 3'd3,
    REG_HUM_CALIB_45  = 3'd4
  } cfg_reg_e;

  // formula constants
  localparam logic [63:0] PRESS_TF_OFFSET = 64'd128000;
  localparam logic [63:0] PRESS_RAW_BASE  = 64'd1048576;
  localparam logic [63:0] PRESS_SCALE     = 64'd3125;
  localparam logic [63:0] PRESS_W_BIAS    = 64'h0000_8000_0000_0000;  // 2^47
  localparam logic [31:0] HUM_TF_OFFSET   = 32'd76800;
  localparam logic [31:0] HUM_CLAMP_MAX   = 32'd419430400;
  localparam logic [31:0] HUM_ROUND_A     = 32'd16384;
  localparam logic [31:0] HUM_BIAS_D      = 32'd2097152;
  localparam logic [31:0] HUM_ROUND_E     = 32'd8192;
  localparam logic [31:0] HUM_BIAS_C      = 32'd32768;
  localparam logic [31:0] TEMP_ROUND      = 32'd128;

  // partial products of a 64x64 product, low 64 bits only
  typedef struct packed {
    logic [63:0] ll;
    logic [31:0] lh;
    logic [31:0] hl;
  } pp64_t;

  // one divider stage word
  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] dq;    // dividend bits out at the top, quotient bits in at the bottom
    logic [63:0] mb;    // divisor magnitude
    logic        neg;
    logic        inv;
    logic [31:0] temp;
    logic [16:0] hum;
  } div_t;

  typedef struct packed {
    logic [63:0] q;
    logic        inv;
    logic [31:0] temp;
    logic [16:0] hum;
  } post_t;

  function automatic logic [31:0] mul_lo32(logic [31:0] a, logic [31:0] b);
    logic [63:0] f;
    f = a * b;
    return f[31:0];
  endfunction

  function automatic pp64_t pp64(logic [63:0] a, logic [63:0] b);
    pp64_t p;
    logic [63:0] f_lh;
    logic [63:0] f_hl;
    p.ll = a[31:0] * b[31:0];
    f_lh = a[31:0] * b[63:32];
    f_hl = a[63:32] * b[31:0];
    p.lh = f_lh[31:0];
    p.hl = f_hl[31:0];
    return p;
  endfunction

  function automatic logic [63:0] pp64_sum(pp64_t p);
    logic [31:0] mid;
    mid = p.lh + p.hl;
    return p.ll + {mid, 32'b0};
  endfunction

  function automatic logic [31:0] asr32(logic [31:0] v, int unsigned n);
    return 32'($signed(v) >>> n);
  endfunction

  function automatic logic [63:0] asr64(logic [63:0] v, int unsigned n);
    return 64'($signed(v) >>> n);
  endfunction

  function automatic logic [63:0] sx16_64(logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sx16_32(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sx8_32(logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

endpackage

/* hdl/env_sensor_compensation.sv */
// env_sensor_compensation: pipelined integer compensation of raw temperature,
// pressure and humidity readings using packed calibration registers.
// Depends on esc_pkg.
//
// Usage
//   Input stream (s_axis_*): one word per raw sample set; tdata holds
//   raw_temp [19:0], raw_press [39:20], raw_hum [55:40].
//   Output stream (m_axis_*): one word per sample set, in order; tdata holds
//   temp_centi [31:0], press_q24_8 [63:32], hum_q7_10 [80:64], zero pad above;
//   tuser is press_invalid (pressure divisor was zero, pressure forced to 0).
//   Config port: cfg_we_i writes cfg_data_i into register cfg_idx_i
//   (0 temp_calib, 1 press_calib_a, 2 press_calib_b, 3 mixed_calib,
//   4 hum_calib_45; other indexes ignored). Write only while the pipe is empty.
// Timing
//   Fully pipelined: one word accepted per cycle while the output is not stalled.
//   The depth is set by the 64-stage restoring divider (one quotient
//   bit per stage) plus the multiply stages ahead of and behind it; every
//   64-bit product is split into 32x32 partial products summed a stage later.
// Reset
//   rst_ni clears all valid bits and the calibration registers to zero.
// Backpressure
//   The last stage is the output register. When it holds a word that is not
//   taken, the whole pipe holds and s_axis_tready drops; nothing is lost.
module env_sensor_compensation (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // raw_temp, raw_press, raw_hum (low to high)
  input  logic [55:0]                      s_axis_tdata,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // temp_centi, press_q24_8, hum_q7_10, zero pad (low to high)
  output logic [87:0]                      m_axis_tdata,
  // press_invalid
  output logic                             m_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic                             cfg_we_i,
  input  logic [esc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [esc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  // ---------------------------------------------------------------- config
  logic [47:0] temp_calib_q;
  logic [63:0] press_calib_a_q;
  logic [63:0] press_calib_b_q;
  logic [55:0] mixed_calib_q;
  logic [23:0] hum_calib_45_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_calib_q    <= '0;
      press_calib_a_q <= '0;
      press_calib_b_q <= '0;
      mixed_calib_q   <= '0;
      hum_calib_45_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (esc_pkg::cfg_reg_e'(cfg_idx_i))
        esc_pkg::REG_TEMP_CALIB:    temp_calib_q    <= cfg_data_i[47:0];
        esc_pkg::REG_PRESS_CALIB_A: press_calib_a_q <= cfg_data_i;
        esc_pkg::REG_PRESS_CALIB_B: press_calib_b_q <= cfg_data_i;
        esc_pkg::REG_MIXED_CALIB:   mixed_calib_q   <= cfg_data_i[55:0];
        esc_pkg::REG_HUM_CALIB_45:  hum_calib_45_q  <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  // calibration fields, sign-extended where signed
  logic [15:0] t1;
  logic [31:0] t2, t3;
  logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [31:0] h1, h2, h3, h4, h5, h6;

  assign t1 = temp_calib_q[15:0];
  assign t2 = esc_pkg::sx16_32(temp_calib_q[31:16]);
  assign t3 = esc_pkg::sx16_32(temp_calib_q[47:32]);
  assign p1 = {48'b0, press_calib_a_q[15:0]};
  assign p2 = esc_pkg::sx16_64(press_calib_a_q[31:16]);
  assign p3 = esc_pkg::sx16_64(press_calib_a_q[47:32]);
  assign p4 = esc_pkg::sx16_64(press_calib_a_q[63:48]);
  assign p5 = esc_pkg::sx16_64(press_calib_b_q[15:0]);
  assign p6 = esc_pkg::sx16_64(press_calib_b_q[31:16]);
  assign p7 = esc_pkg::sx16_64(press_calib_b_q[47:32]);
  assign p8 = esc_pkg::sx16_64(press_calib_b_q[63:48]);
  assign p9 = esc_pkg::sx16_64(mixed_calib_q[15:0]);
  assign h1 = {24'b0, mixed_calib_q[23:16]};
  assign h2 = esc_pkg::sx16_32(mixed_calib_q[39:24]);
  assign h3 = {24'b0, mixed_calib_q[47:40]};
  assign h6 = esc_pkg::sx8_32(mixed_calib_q[55:48]);
  assign h4 = {20'b0, hum_calib_45_q[11:0]};
  assign h5 = {20'b0, hum_calib_45_q[23:12]};

  // ------------------------------------------------------------ flow ctrl
  logic                               adv;
  logic [esc_pkg::NUM_STAGES-1:0]     vld_q;

  assign adv           = !vld_q[esc_pkg::NUM_STAGES-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[esc_pkg::NUM_STAGES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[esc_pkg::NUM_STAGES-2:0], s_axis_tvalid};
    end
  end

  // ------------------------------------------------------- front stages
  logic [19:0] raw_temp, raw_press;
  logic [15:0] raw_hum;
  assign raw_temp  = s_axis_tdata[19:0];
  assign raw_press = s_axis_tdata[39:20];
  assign raw_hum   = s_axis_tdata[55:40];

  logic [19:0] adcp_dly_q [10];  // stages 1..10
  logic [15:0] adch_dly_q [6];   // stages 1..6
  logic [31:0] temp_dly_q [10];  // stages 5..14

  logic [31:0] s1_ta_q, s1_d_q;
  logic [31:0] s2_ma_q, s2_dd_q;
  logic [31:0] s3_a_q, s3_mb_q;
  logic [31:0] s4_tf_q;
  logic [63:0] s5_v1_q;
  logic [31:0] s5_x_q;
  logic [31:0] s5_temp;
  logic [31:0] s4_tf5;

  esc_pkg::pp64_t s6_sq_q, s6_v5_q, s6_v2_q;
  logic [31:0]    s6_h5x_q, s6_hbm_q, s6_hcm_q;
  logic [63:0]    v5_dly_q [3];   // stages 7..9
  logic [63:0]    v2p_dly_q [3];  // stages 7..9
  logic [63:0]    s7_sq_q;
  logic [31:0]    ha_dly_q [5];   // stages 7..11
  logic [31:0]    s7_hb_q, s7_hc_q;
  esc_pkg::pp64_t s8_s6_q, s8_s3_q;
  logic [31:0]    s8_hbc_q;
  logic [63:0]    s9_s6_q, s9_s3_q;
  logic [31:0]    s9_hd_q;
  logic [63:0]    s10_v2_q, s10_w_q;
  logic [31:0]    s10_hd2_q;
  esc_pkg::pp64_t s11_wp_q;
  logic [63:0]    s11_num0_q;
  logic [31:0]    s11_he_q;
  logic [63:0]    den_dly_q [3];  // stages 12..14
  esc_pkg::pp64_t s12_nm_q;
  logic [31:0]    hx_dly_q [3];   // stages 12..14
  logic [63:0]    num_dly_q [2];  // stages 13..14
  logic [31:0]    s13_hss_q;
  logic [31:0]    s14_th_q;

  logic [63:0] s10_pd;
  logic [31:0] s13_hs;
  logic [31:0] s7_ha_sum;

  assign s4_tf5    = {s4_tf_q[29:0], 2'b0} + s4_tf_q + esc_pkg::TEMP_ROUND;
  assign s5_temp   = esc_pkg::asr32(s4_tf5, 8);
  assign s10_pd    = esc_pkg::PRESS_RAW_BASE - {44'b0, adcp_dly_q[9]};
  assign s13_hs    = esc_pkg::asr32(hx_dly_q[0], 15);
  assign s7_ha_sum = {2'b0, adch_dly_q[5], 14'b0} - {h4[11:0], 20'b0} - s6_h5x_q
                     + esc_pkg::HUM_ROUND_A;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // stage 1: raw differences
      s1_ta_q       <= {15'b0, raw_temp[19:3]} - {15'b0, t1, 1'b0};
      s1_d_q        <= {16'b0, raw_temp[19:4]} - {16'b0, t1};
      adcp_dly_q[0] <= raw_press;
      adch_dly_q[0] <= raw_hum;
      for (int i = 1; i < 10; i++) adcp_dly_q[i] <= adcp_dly_q[i-1];
      for (int i = 1; i < 6; i++)  adch_dly_q[i] <= adch_dly_q[i-1];
      // stage 2..4: fine temperature
      s2_ma_q <= esc_pkg::mul_lo32(s1_ta_q, t2);
      s2_dd_q <= esc_pkg::mul_lo32(s1_d_q, s1_d_q);
      s3_a_q  <= esc_pkg::asr32(s2_ma_q, 11);
      s3_mb_q <= esc_pkg::mul_lo32(esc_pkg::asr32(s2_dd_q, 12), t3);
      s4_tf_q <= s3_a_q + esc_pkg::asr32(s3_mb_q, 14);
      // stage 5: temperature out, pressure/humidity offsets
      temp_dly_q[0] <= s5_temp;
      for (int i = 1; i < 10; i++) temp_dly_q[i] <= temp_dly_q[i-1];
      s5_v1_q <= {{32{s4_tf_q[31]}}, s4_tf_q} - esc_pkg::PRESS_TF_OFFSET;
      s5_x_q  <= s4_tf_q - esc_pkg::HUM_TF_OFFSET;
      // stage 6: first products
      s6_sq_q  <= esc_pkg::pp64(s5_v1_q, s5_v1_q);
      s6_v5_q  <= esc_pkg::pp64(s5_v1_q, p5);
      s6_v2_q  <= esc_pkg::pp64(s5_v1_q, p2);
      s6_h5x_q <= esc_pkg::mul_lo32(h5, s5_x_q);
      s6_hbm_q <= esc_pkg::mul_lo32(s5_x_q, h6);
      s6_hcm_q <= esc_pkg::mul_lo32(s5_x_q, h3);
      // stage 7
      s7_sq_q      <= esc_pkg::pp64_sum(s6_sq_q);
      v5_dly_q[0]  <= esc_pkg::pp64_sum(s6_v5_q);
      v2p_dly_q[0] <= esc_pkg::pp64_sum(s6_v2_q);
      for (int i = 1; i < 3; i++) begin
        v5_dly_q[i]  <= v5_dly_q[i-1];
        v2p_dly_q[i] <= v2p_dly_q[i-1];
      end
      ha_dly_q[0] <= esc_pkg::asr32(s7_ha_sum, 15);
      for (int i = 1; i < 5; i++) ha_dly_q[i] <= ha_dly_q[i-1];
      s7_hb_q <= esc_pkg::asr32(s6_hbm_q, 10);
      s7_hc_q <= esc_pkg::asr32(s6_hcm_q, 11) + esc_pkg::HUM_BIAS_C;
      // stage 8
      s8_s6_q  <= esc_pkg::pp64(s7_sq_q, p6);
      s8_s3_q  <= esc_pkg::pp64(s7_sq_q, p3);
      s8_hbc_q <= esc_pkg::mul_lo32(s7_hb_q, s7_hc_q);
      // stage 9
      s9_s6_q <= esc_pkg::pp64_sum(s8_s6_q);
      s9_s3_q <= esc_pkg::pp64_sum(s8_s3_q);
      s9_hd_q <= esc_pkg::asr32(s8_hbc_q, 10) + esc_pkg::HUM_BIAS_D;
      // stage 10: divisor pre-term, dividend offset term
      s10_v2_q  <= s9_s6_q + {v5_dly_q[2][46:0], 17'b0} + {p4[28:0], 35'b0};
      s10_w_q   <= esc_pkg::asr64(s9_s3_q, 8) + {v2p_dly_q[2][51:0], 12'b0}
                   + esc_pkg::PRESS_W_BIAS;
      s10_hd2_q <= esc_pkg::mul_lo32(s9_hd_q, h2);
      // stage 11
      s11_wp_q   <= esc_pkg::pp64(s10_w_q, p1);
      s11_num0_q <= {s10_pd[32:0], 31'b0} - s10_v2_q;
      s11_he_q   <= esc_pkg::asr32(s10_hd2_q + esc_pkg::HUM_ROUND_E, 14);
      // stage 12
      den_dly_q[0] <= esc_pkg::asr64(esc_pkg::pp64_sum(s11_wp_q), 33);
      for (int i = 1; i < 3; i++) den_dly_q[i] <= den_dly_q[i-1];
      s12_nm_q     <= esc_pkg::pp64(s11_num0_q, esc_pkg::PRESS_SCALE);
      hx_dly_q[0]  <= esc_pkg::mul_lo32(ha_dly_q[4], s11_he_q);
      for (int i = 1; i < 3; i++) hx_dly_q[i] <= hx_dly_q[i-1];
      // stage 13
      num_dly_q[0] <= esc_pkg::pp64_sum(s12_nm_q);
      num_dly_q[1] <= num_dly_q[0];
      s13_hss_q    <= esc_pkg::mul_lo32(s13_hs, s13_hs);
      // stage 14
      s14_th_q <= esc_pkg::mul_lo32(esc_pkg::asr32(s13_hss_q, 7), h1);
    end
  end

  // stage 15: divider setup and humidity clamp
  logic        na, nb;
  logic [63:0] num15, den15;
  logic [31:0] hx15, hclamp;
  logic [16:0] hum15;
  esc_pkg::div_t s15_d;

  assign num15  = num_dly_q[1];
  assign den15  = den_dly_q[2];
  assign na     = num15[63];
  assign nb     = den15[63];
  assign hx15   = hx_dly_q[2] - esc_pkg::asr32(s14_th_q, 4);

  always_comb begin
    priority if (hx15[31]) begin
      hclamp = '0;
    end else if (hx15 > esc_pkg::HUM_CLAMP_MAX) begin
      hclamp = esc_pkg::HUM_CLAMP_MAX;
    end else begin
      hclamp = hx15;
    end
  end
  assign hum15 = hclamp[28:12];

  always_comb begin
    s15_d.rem  = '0;
    s15_d.dq   = na ? (64'd0 - num15) : num15;
    s15_d.mb   = nb ? (64'd0 - den15) : den15;
    s15_d.neg  = na ^ nb;
    s15_d.inv  = (den15 == 64'd0);
    s15_d.temp = temp_dly_q[9];
    s15_d.hum  = hum15;
  end

  esc_pkg::div_t div_in_q;
  esc_pkg::div_t div_q [esc_pkg::DIV_STEPS];

  always_ff @(posedge clk_i) begin
    if (adv) div_in_q <= s15_d;
  end

  // ------------------------------------------- restoring divider, 1 bit/stage
  for (genvar k = 0; k < esc_pkg::DIV_STEPS; k++) begin : g_div
    esc_pkg::div_t cur, nxt;
    logic [63:0]   trial;
    logic [64:0]   diff;

    if (k == 0) begin : g_first
      assign cur = div_in_q;
    end else begin : g_rest
      assign cur = div_q[k-1];
    end

    assign trial = {cur.rem[62:0], cur.dq[63]};
    assign diff  = {1'b0, trial} - {1'b0, cur.mb};

    always_comb begin
      nxt     = cur;
      nxt.rem = diff[64] ? trial : diff[63:0];
      nxt.dq  = {cur.dq[62:0], !diff[64]};
    end

    always_ff @(posedge clk_i) begin
      if (adv) div_q[k] <= nxt;
    end
  end

  // --------------------------------------------------------- back stages
  esc_pkg::div_t  div_last;
  esc_pkg::post_t pst0_d;
  assign div_last = div_q[esc_pkg::DIV_STEPS-1];

  always_comb begin
    pst0_d.q    = div_last.neg ? (64'd0 - div_last.dq) : div_last.dq;
    pst0_d.inv  = div_last.inv;
    pst0_d.temp = div_last.temp;
    pst0_d.hum  = div_last.hum;
  end

  esc_pkg::post_t pst_q [6];  // stages 80..85
  logic [63:0]    a1_qq_q, a2_qq_q;
  esc_pkg::pp64_t a1_p9q_q, a1_p8q_q, a3_w1_q;
  logic [63:0]    a2_p9q_q, a2_p8q_q, a3_p8q_q;
  logic [63:0]    a4_w1_q, a4_w2_q, a5_s_q;
  logic [63:0]    a1_qq;
  logic [63:0]    press_full;
  logic [31:0]    out_temp_q, out_press_q;
  logic [16:0]    out_hum_q;
  logic           out_inv_q;

  assign a1_qq      = esc_pkg::asr64(pst_q[0].q, 13);
  assign press_full = esc_pkg::asr64(a5_s_q, 8) + {p7[59:0], 4'b0};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pst_q[0] <= pst0_d;
      for (int i = 1; i < 6; i++) pst_q[i] <= pst_q[i-1];
      // stage 81
      a1_qq_q  <= a1_qq;
      a1_p9q_q <= esc_pkg::pp64(p9, a1_qq);
      a1_p8q_q <= esc_pkg::pp64(p8, pst_q[0].q);
      // stage 82
      a2_qq_q  <= a1_qq_q;
      a2_p9q_q <= esc_pkg::pp64_sum(a1_p9q_q);
      a2_p8q_q <= esc_pkg::pp64_sum(a1_p8q_q);
      // stage 83
      a3_w1_q  <= esc_pkg::pp64(a2_p9q_q, a2_qq_q);
      a3_p8q_q <= a2_p8q_q;
      // stage 84
      a4_w1_q <= esc_pkg::asr64(esc_pkg::pp64_sum(a3_w1_q), 25);
      a4_w2_q <= esc_pkg::asr64(a3_p8q_q, 19);
      // stage 85
      a5_s_q <= pst_q[4].q + a4_w1_q + a4_w2_q;
      // stage 86: output register
      out_temp_q  <= pst_q[5].temp;
      out_hum_q   <= pst_q[5].hum;
      out_inv_q   <= pst_q[5].inv;
      out_press_q <= pst_q[5].inv ? 32'd0 : press_full[31:0];
    end
  end

  assign m_axis_tdata = {7'b0, out_hum_q, out_press_q, out_temp_q};
  assign m_axis_tuser = out_inv_q;

endmodule
